// ----- rtl/core/pwi_pkg.sv -----
// Shared constants, register codes and types for the field weave interlacer.
`default_nettype none

package pwi_pkg;

    localparam int MAX_FRAME_BYTES = 4194304;

    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam int SIZE_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam int BYTE_W = 8;
    localparam int LB_W = 14;
    localparam int LC_W = 13;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_INDEX_W = 2;

    localparam int LB_MIN = 1;
    localparam int LB_MAX = 8192;
    localparam int LC_MIN = 2;
    localparam int LC_MAX = 4096;

    localparam int OFFSET_W = $clog2(LB_MAX);
    localparam int LUMA_W = LB_W + LC_W;
    localparam int CHROMA_W = LB_W + LC_W - 1;
    localparam int TOTAL_W = LUMA_W + 1;

    localparam int RESET_LINE_BYTES = 3840;
    localparam int RESET_LINE_COUNT = 1080;
    localparam int RESET_PLANAR = 0;

    localparam longint RESET_LUMA = longint'(RESET_LINE_BYTES) * RESET_LINE_COUNT;
    localparam longint RESET_TOTAL = RESET_LUMA + ((RESET_PLANAR != 0) ?
        2 * longint'((RESET_LINE_BYTES + 1) / 2) * (RESET_LINE_COUNT / 2) : 0);
    localparam bit RESET_FAULT = ((RESET_LINE_COUNT % 2) != 0)
        || (RESET_LINE_BYTES < LB_MIN) || (RESET_LINE_BYTES > LB_MAX)
        || (RESET_LINE_COUNT < LC_MIN) || (RESET_LINE_COUNT > LC_MAX)
        || (RESET_TOTAL > MAX_FRAME_BYTES);
    localparam longint RESET_LUMA_SIZE = RESET_FAULT ? 0 : RESET_LUMA;
    localparam longint RESET_FRAME_SIZE = RESET_FAULT ? 0 : RESET_TOTAL;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_BYTES  = 2'd0,
        REG_LINE_COUNT  = 2'd1,
        REG_PLANAR_MODE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              restart;
        logic              busy;
        logic              fault;
        logic [LB_W-1:0]   line_bytes;
        logic [SIZE_W-1:0] luma_size;
        logic [SIZE_W-1:0] frame_size;
    } cfg_info_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwi_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pwi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pwi_cfg.sv -----
// Configuration registers and two-stage frame size and fault calculation.
`default_nettype none

module pwi_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              write_en,
    input  wire logic [pwi_pkg::CFG_INDEX_W-1:0]   index,
    input  wire logic [pwi_pkg::CFG_DATA_W-1:0]    data,
    output pwi_pkg::cfg_info_t                     info
);

    logic [pwi_pkg::LB_W-1:0]     lb_reg, lb_next;
    logic [pwi_pkg::LC_W-1:0]     lc_reg, lc_next;
    logic                         planar_reg, planar_next;
    logic                         restart;

    logic                         calc1_reg, calc2_reg;
    logic [pwi_pkg::LUMA_W-1:0]   luma_reg;
    logic [pwi_pkg::CHROMA_W-1:0] chroma_reg;
    logic                         range_bad_reg;
    logic                         planar_a_reg;

    logic [pwi_pkg::LB_W-1:0]     half_w;
    logic [pwi_pkg::LC_W-2:0]     half_h;
    logic                         range_bad;
    logic [pwi_pkg::TOTAL_W-1:0]  total;
    logic                         fault;

    logic                         fault_reg;
    logic [pwi_pkg::SIZE_W-1:0]   luma_size_reg, frame_size_reg;

    always_comb
    begin
        lb_next = lb_reg;
        lc_next = lc_reg;
        planar_next = planar_reg;
        restart = 1'b0;
        if (write_en)
        begin
            case (index)
                pwi_pkg::REG_LINE_BYTES:
                begin
                    lb_next = data[pwi_pkg::LB_W-1:0];
                    restart = 1'b1;
                end
                pwi_pkg::REG_LINE_COUNT:
                begin
                    lc_next = data[pwi_pkg::LC_W-1:0];
                    restart = 1'b1;
                end
                pwi_pkg::REG_PLANAR_MODE:
                begin
                    planar_next = data[0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_reg <= pwi_pkg::LB_W'(pwi_pkg::RESET_LINE_BYTES);
            lc_reg <= pwi_pkg::LC_W'(pwi_pkg::RESET_LINE_COUNT);
            planar_reg <= 1'(pwi_pkg::RESET_PLANAR);
            calc1_reg <= 1'b0;
            calc2_reg <= 1'b0;
        end
        else
        begin
            lb_reg <= lb_next;
            lc_reg <= lc_next;
            planar_reg <= planar_next;
            calc1_reg <= restart;
            calc2_reg <= calc1_reg;
        end
    end

    // stage one: products and range checks
    assign half_w = pwi_pkg::LB_W'(({1'b0, lb_reg} + (pwi_pkg::LB_W + 1)'(1)) >> 1);
    assign half_h = lc_reg[pwi_pkg::LC_W-1:1];
    assign range_bad = lc_reg[0]
        || (lb_reg < pwi_pkg::LB_W'(pwi_pkg::LB_MIN))
        || (lb_reg > pwi_pkg::LB_W'(pwi_pkg::LB_MAX))
        || (lc_reg < pwi_pkg::LC_W'(pwi_pkg::LC_MIN))
        || (lc_reg > pwi_pkg::LC_W'(pwi_pkg::LC_MAX));

    always_ff @(posedge clk)
    begin
        luma_reg <= pwi_pkg::LUMA_W'(lb_reg) * pwi_pkg::LUMA_W'(lc_reg);
        chroma_reg <= pwi_pkg::CHROMA_W'(half_w) * pwi_pkg::CHROMA_W'(half_h);
        range_bad_reg <= range_bad;
        planar_a_reg <= planar_reg;
    end

    // stage two: frame total and fault
    assign total = pwi_pkg::TOTAL_W'(luma_reg)
        + (planar_a_reg ? pwi_pkg::TOTAL_W'({chroma_reg, 1'b0}) : pwi_pkg::TOTAL_W'(0));
    assign fault = range_bad_reg || (total > pwi_pkg::TOTAL_W'(pwi_pkg::MAX_FRAME_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= pwi_pkg::RESET_FAULT;
            luma_size_reg <= pwi_pkg::SIZE_W'(pwi_pkg::RESET_LUMA_SIZE);
            frame_size_reg <= pwi_pkg::SIZE_W'(pwi_pkg::RESET_FRAME_SIZE);
        end
        else if (calc2_reg)
        begin
            fault_reg <= fault;
            luma_size_reg <= fault ? '0 : luma_reg[pwi_pkg::SIZE_W-1:0];
            frame_size_reg <= fault ? '0 : total[pwi_pkg::SIZE_W-1:0];
        end
    end

    always_comb
    begin
        info.restart = restart;
        info.busy = write_en | calc1_reg | calc2_reg;
        info.fault = fault_reg;
        info.line_bytes = lb_reg;
        info.luma_size = luma_size_reg;
        info.frame_size = frame_size_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/progressive_to_interlaced_weave.sv -----
// Top level of the field weave interlacer: position counters, store access, output stage.
// Path: an accepted input item passes the stage-one register, then the output register.
// Throughput: one item per cycle while in_stall is low; first-frame items write the
// store and give nothing. A register write stalls the input during the write and while
// the frame size and fault are recomputed by the two-stage multiplier path.
// Reset (async, rst_n low) restores the default registers and clears control state;
// the frame store is not cleared and needs no clearing pass.
`default_nettype none

module progressive_to_interlaced_weave (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [pwi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pwi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pwi_pkg::BYTE_W-1:0]        pixel_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [pwi_pkg::BYTE_W-1:0]        woven_byte,
    output logic                                   frame_last
);

    pwi_pkg::cfg_info_t cfg_info;

    logic                          holding_reg, holding_next;
    logic [pwi_pkg::OFFSET_W-1:0]  offset_reg, offset_next;
    logic                          odd_reg, odd_next;
    logic [pwi_pkg::ADDR_W-1:0]    pos_reg, pos_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic [pwi_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic                          s1_odd_reg;
    logic                          s1_luma_reg;
    logic                          s1_last_reg;
    logic                          s1_adv;

    logic                          out_valid_reg, out_valid_next;
    logic [pwi_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          active;
    logic [pwi_pkg::SIZE_W-1:0]    pos_inc;
    logic                          is_last;
    logic [pwi_pkg::LB_W-1:0]      offset_inc;
    logic                          wrap;
    logic                          ram_wr_en, ram_rd_en;
    logic [pwi_pkg::BYTE_W-1:0]    ram_rd_data;

    pwi_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .info     (cfg_info)
    );

    pwi_ram #(
        .WIDTH (pwi_pkg::BYTE_W),
        .DEPTH (pwi_pkg::MAX_FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (pixel_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    assign s1_adv = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = cfg_info.busy | (s1_valid_reg & ~s1_adv);
    assign accept = in_valid & ~in_stall;

    assign pos_inc = pwi_pkg::SIZE_W'(pos_reg) + pwi_pkg::SIZE_W'(1);
    assign is_last = (pos_inc == cfg_info.frame_size);
    assign active = accept & ~cfg_info.fault
        & (pwi_pkg::SIZE_W'(pos_reg) < cfg_info.frame_size);
    assign offset_inc = pwi_pkg::LB_W'(offset_reg) + pwi_pkg::LB_W'(1);
    assign wrap = (offset_inc >= cfg_info.line_bytes);

    assign ram_wr_en = active & ~holding_reg;
    assign ram_rd_en = active & holding_reg;

    always_comb
    begin
        holding_next = holding_reg;
        offset_next = offset_reg;
        odd_next = odd_reg;
        pos_next = pos_reg;
        if (cfg_info.restart)
        begin
            holding_next = 1'b0;
            offset_next = '0;
            odd_next = 1'b0;
            pos_next = '0;
        end
        else if (active)
        begin
            if (is_last)
            begin
                holding_next = ~holding_reg;
                offset_next = '0;
                odd_next = 1'b0;
                pos_next = '0;
            end
            else
            begin
                offset_next = wrap ? '0 : offset_inc[pwi_pkg::OFFSET_W-1:0];
                odd_next = odd_reg ^ wrap;
                pos_next = pos_inc[pwi_pkg::ADDR_W-1:0];
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ram_rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
            offset_reg <= '0;
            odd_reg <= 1'b0;
            pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            holding_reg <= holding_next;
            offset_reg <= offset_next;
            odd_reg <= odd_next;
            pos_reg <= pos_next;
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            s1_byte_reg <= pixel_byte;
            s1_odd_reg <= odd_reg;
            s1_luma_reg <= (pwi_pkg::SIZE_W'(pos_reg) < cfg_info.luma_size);
            s1_last_reg <= is_last;
        end
        if (s1_adv)
        begin
            // odd luma lines from the live frame, the rest from the store
            out_byte_reg <= (s1_luma_reg && s1_odd_reg) ? s1_byte_reg : ram_rd_data;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign woven_byte = out_byte_reg;
    assign frame_last = out_last_reg;

`ifndef SYNTH
    a_no_read_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !ram_rd_en)
        else $error("store read while stage one is held");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_info.fault && !cfg_info.busy)
            |-> (pwi_pkg::SIZE_W'(pos_reg) < cfg_info.frame_size))
        else $error("frame position beyond frame size");

    a_offset_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_info.fault && !cfg_info.busy)
            |-> (pwi_pkg::LB_W'(offset_reg) < cfg_info.line_bytes))
        else $error("line offset beyond line length");
`endif

endmodule

`default_nettype wire
